>>> rtl/text_console_cell_writer_defines.svh
// ----------------------------------------------------------------------------
// Text console cell writer: shared assertion macros
// Immediate-consequence and next-cycle property wrappers with reset disable.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TCCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tccw: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TCCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tccw: next-cycle check failed");

`endif

>>> rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Types and constants shared by the text console cell writer modules.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int COL_W       = 7;
    localparam int ROW_W       = 5;
    localparam int ADDR_W      = 11;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int DATA_W      = ATTR_W + CHAR_W;
    localparam int NUM_W       = 32;
    localparam int DIGITS      = 10;
    localparam int DIGIT_W     = 4;
    localparam int BCD_W       = DIGITS * DIGIT_W;
    localparam int BIT_CNT_W   = $clog2(NUM_W);
    localparam int DIG_CNT_W   = $clog2(DIGITS + 1);

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [CHAR_W-1:0] NL_CODE    = 8'h0A;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } tccw_state_t;

    typedef struct packed {
        logic load;        // capture input word, clear converter
        logic newline;     // move cursor to next row start
        logic write_char;  // write held character
        logic conv_step;   // one double-dabble step
        logic skip_step;   // drop a leading zero digit
        logic write_digit; // write top digit and drop it
    } tccw_cmd_t;

    typedef struct packed {
        logic slot_free;   // output register can take a word this cycle
        logic is_newline;  // held character is a newline
        logic conv_last;   // final conversion step
        logic top_zero;    // leading BCD digit is zero
        logic digit_last;  // one digit left to write
    } tccw_sts_t;

endpackage

>>> rtl/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer for character writes and number-to-decimal conversion.
// ----------------------------------------------------------------------------
module tccw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_func,
    input  tccw_pkg::tccw_sts_t sts,
    output logic                in_ready,
    output tccw_pkg::tccw_cmd_t cmd
);

    tccw_pkg::tccw_state_t state_reg;
    tccw_pkg::tccw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tccw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tccw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_func ? tccw_pkg::ST_CONV : tccw_pkg::ST_CHAR;
                end
            end
            tccw_pkg::ST_CHAR:
            begin
                if (sts.is_newline || sts.slot_free)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_CONV:
            begin
                if (sts.conv_last)
                begin
                    state_next = tccw_pkg::ST_SKIP;
                end
            end
            tccw_pkg::ST_SKIP:
            begin
                if (!sts.top_zero || sts.digit_last)
                begin
                    state_next = tccw_pkg::ST_EMIT;
                end
            end
            tccw_pkg::ST_EMIT:
            begin
                if (sts.slot_free && sts.digit_last)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tccw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            tccw_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            tccw_pkg::ST_CHAR:
            begin
                cmd.newline    = sts.is_newline;
                cmd.write_char = !sts.is_newline && sts.slot_free;
            end
            tccw_pkg::ST_CONV:
            begin
                cmd.conv_step = 1'b1;
            end
            tccw_pkg::ST_SKIP:
            begin
                cmd.skip_step = sts.top_zero && !sts.digit_last;
            end
            tccw_pkg::ST_EMIT:
            begin
                cmd.write_digit = sts.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/tccw_dp.sv
// ----------------------------------------------------------------------------
// tccw_dp
// Cursor, attribute register, binary-to-BCD shifter and output register.
// ----------------------------------------------------------------------------
module tccw_dp #(
    parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tccw_pkg::ATTR_W-1:0]        cfg_wdata,
    input  logic [tccw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tccw_pkg::NUM_W-1:0]         number,
    input  tccw_pkg::tccw_cmd_t                cmd,
    output tccw_pkg::tccw_sts_t                sts,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [tccw_pkg::ADDR_W-1:0]        cell_address,
    output logic [tccw_pkg::DATA_W-1:0]        cell_data,
    output logic                               last_write
);

    localparam int PROD_W = tccw_pkg::ROW_W + tccw_pkg::COL_W;
    localparam logic [tccw_pkg::COL_W-1:0] COL_LIM = tccw_pkg::COL_W'(COLUMNS);
    localparam logic [tccw_pkg::ROW_W-1:0] ROW_LIM = tccw_pkg::ROW_W'(ROWS);

    logic [tccw_pkg::ATTR_W-1:0]    attr_reg, attr_next;
    logic [tccw_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [tccw_pkg::COL_W-1:0]     col_reg, col_next;
    logic [tccw_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic [tccw_pkg::NUM_W-1:0]     bin_reg, bin_next;
    logic [tccw_pkg::BCD_W-1:0]     bcd_reg, bcd_next;
    logic [tccw_pkg::BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [tccw_pkg::DIG_CNT_W-1:0] dig_cnt_reg, dig_cnt_next;
    logic                           out_valid_reg, out_valid_next;
    logic [tccw_pkg::ADDR_W-1:0]    addr_reg, addr_next;
    logic [tccw_pkg::DATA_W-1:0]    data_reg, data_next;
    logic                           last_reg, last_next;

    logic [tccw_pkg::BCD_W-1:0]     bcd_adj;
    logic [tccw_pkg::DIGIT_W-1:0]   top_digit;
    logic [PROD_W-1:0]              addr_full;
    logic [tccw_pkg::ROW_W-1:0]     row_inc;
    logic [tccw_pkg::COL_W-1:0]     col_inc;
    logic                           do_write;
    logic [tccw_pkg::CHAR_W-1:0]    wr_code;

    assign top_digit = bcd_reg[tccw_pkg::BCD_W-1 -: tccw_pkg::DIGIT_W];

    assign sts.slot_free  = !out_valid_reg || out_ready;
    assign sts.is_newline = (char_reg == tccw_pkg::NL_CODE);
    assign sts.conv_last  = (bit_cnt_reg == '0);
    assign sts.top_zero   = (top_digit == '0);
    assign sts.digit_last = (dig_cnt_reg == tccw_pkg::DIG_CNT_W'(1));

    // add-3 correction on every digit before the shift
    always_comb
    begin
        for (int i = 0; i < tccw_pkg::DIGITS; i++)
        begin
            if (bcd_reg[i*tccw_pkg::DIGIT_W +: tccw_pkg::DIGIT_W] >= 4'd5)
            begin
                bcd_adj[i*tccw_pkg::DIGIT_W +: tccw_pkg::DIGIT_W] =
                    bcd_reg[i*tccw_pkg::DIGIT_W +: tccw_pkg::DIGIT_W] + 4'd3;
            end
            else
            begin
                bcd_adj[i*tccw_pkg::DIGIT_W +: tccw_pkg::DIGIT_W] =
                    bcd_reg[i*tccw_pkg::DIGIT_W +: tccw_pkg::DIGIT_W];
            end
        end
    end

    assign addr_full = PROD_W'(row_reg) * PROD_W'(COL_LIM) + PROD_W'(col_reg);
    assign row_inc   = row_reg + 1'b1;
    assign col_inc   = col_reg + 1'b1;
    assign do_write  = cmd.write_char || cmd.write_digit;
    assign wr_code   = cmd.write_digit ? (tccw_pkg::ASCII_ZERO | tccw_pkg::CHAR_W'(top_digit))
                                       : char_reg;

    always_comb
    begin
        attr_next      = cfg_we ? cfg_wdata : attr_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        char_next      = char_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        addr_next      = addr_reg;
        data_next      = data_reg;
        last_next      = last_reg;

        if (cmd.load)
        begin
            char_next    = char_code;
            bin_next     = number;
            bcd_next     = '0;
            bit_cnt_next = tccw_pkg::BIT_CNT_W'(tccw_pkg::NUM_W - 1);
            dig_cnt_next = tccw_pkg::DIG_CNT_W'(tccw_pkg::DIGITS);
        end

        if (cmd.conv_step)
        begin
            bcd_next     = {bcd_adj[tccw_pkg::BCD_W-2:0], bin_reg[tccw_pkg::NUM_W-1]};
            bin_next     = {bin_reg[tccw_pkg::NUM_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end

        if (cmd.skip_step || cmd.write_digit)
        begin
            bcd_next     = {bcd_reg[tccw_pkg::BCD_W-tccw_pkg::DIGIT_W-1:0],
                            {tccw_pkg::DIGIT_W{1'b0}}};
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end

        if (do_write)
        begin
            out_valid_next = 1'b1;
            addr_next      = addr_full[tccw_pkg::ADDR_W-1:0];
            data_next      = {attr_reg, wr_code};
            last_next      = cmd.write_char || sts.digit_last;
            if (col_inc >= COL_LIM)
            begin
                col_next = '0;
                row_next = (row_inc >= ROW_LIM) ? '0 : row_inc;
            end
            else
            begin
                col_next = col_inc;
            end
        end
        else if (cmd.newline)
        begin
            col_next = '0;
            row_next = (row_inc >= ROW_LIM) ? '0 : row_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= tccw_pkg::ATTR_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
        end
        else
        begin
            attr_reg      <= attr_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        addr_reg <= addr_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign cell_address = addr_reg;
    assign cell_data    = data_reg;
    assign last_write   = last_reg;

endmodule

>>> rtl/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text screen writer with row/column cursor; characters and decimal numbers.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  in       | in_valid / in_ready  | func, char_code, number
//  out      | out_valid / out_ready| cell_address, cell_data, last_write
//  cfg      | cfg_we               | cfg_wdata (cell attribute)
//
//  Character or newline word: accepted, then written or cursor moved.
//  Number word: accepted, then the 32-step binary-to-BCD shift loop runs,
//  followed by the digit slots (10 total), with leading zero digits skipped.
//  One word at a time; a finished cell word sits in the output register while
//  the next input word is accepted. Output stalls hold digit emission.
//  rst_n is asynchronous; attribute resets to 0x07, cursor to row 0 col 0.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
    parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tccw_pkg::ATTR_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        func,
    input  logic [tccw_pkg::CHAR_W-1:0] char_code,
    input  logic [tccw_pkg::NUM_W-1:0]  number,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tccw_pkg::ADDR_W-1:0] cell_address,
    output logic [tccw_pkg::DATA_W-1:0] cell_data,
    output logic                        last_write
);

    tccw_pkg::tccw_cmd_t cmd;
    tccw_pkg::tccw_sts_t sts;

    tccw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (func),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    tccw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .char_code    (char_code),
        .number       (number),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .cell_address (cell_address),
        .cell_data    (cell_data),
        .last_write   (last_write)
    );

endmodule

>>> rtl/tccw_chk.sv
// ----------------------------------------------------------------------------
// tccw_chk
// Port-level checks for the text console cell writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_defines.svh"

module tccw_chk #(
    parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [tccw_pkg::ADDR_W-1:0] cell_address,
    input logic [tccw_pkg::DATA_W-1:0] cell_data,
    input logic                        last_write
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam logic [tccw_pkg::ADDR_W:0] CELL_LIM = (tccw_pkg::ADDR_W+1)'(CELLS);
    localparam logic ADDR_WRAPS = (CELLS > (1 << tccw_pkg::ADDR_W));

    logic [tccw_pkg::ADDR_W:0] addr_ext;
    assign addr_ext = {1'b0, cell_address};

    // stalled output word must hold
    `TCCW_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(cell_address) && $stable(cell_data) && $stable(last_write))
    // cell index stays on screen
    `TCCW_ASSERT_IMP(a_addr_range, clk, rst_n, out_valid, ADDR_WRAPS || (addr_ext < CELL_LIM))
    // a newline never lands in a cell
    `TCCW_ASSERT_IMP(a_no_newline, clk, rst_n, out_valid, cell_data[tccw_pkg::CHAR_W-1:0] != tccw_pkg::NL_CODE)
    // one word in flight: input closes right after an accept
    `TCCW_ASSERT_NXT(a_one_word, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind text_console_cell_writer tccw_chk #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccw_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_address (cell_address),
    .cell_data    (cell_data),
    .last_write   (last_write)
);
